FILE: hdl/seven_segment_scan_blink_driver_defines.svh
// Assertion macros shared by the display driver RTL.
`ifndef SEVEN_SEGMENT_SCAN_BLINK_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_BLINK_DRIVER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define SSBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssbd check failed");
// Next-cycle implication, checked out of reset
`define SSBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssbd check failed");
`else
`define SSBD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SSBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/ssbd_pkg.sv
// Shared constants, types and the glyph decoder of the display driver.
package ssbd_pkg;

    localparam int POS_COUNT   = 8;
    localparam int POS_W       = $clog2(POS_COUNT);
    localparam int DIGIT_COUNT = 6;
    localparam int SEG_W       = 8;
    localparam int PERIOD_W    = 16;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [POS_W-1:0] COLON_POS = POS_W'(6);
    localparam logic [POS_W-1:0] LED_POS   = POS_W'(7);

    // Request modes
    localparam logic [1:0] MODE_TICK        = 2'd0;
    localparam logic [1:0] MODE_WRITE_CHAR  = 2'd1;
    localparam logic [1:0] MODE_SET_BLINK   = 2'd2;
    localparam logic [1:0] MODE_CLEAR_BLINK = 2'd3;

    // Register select (paddr bit 2)
    localparam logic REG_BLINK_ENABLE = 1'b0;
    localparam logic REG_BLINK_PERIOD = 1'b1;

    localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RESET = PERIOD_W'(200);
    localparam logic [SEG_W-1:0]    SEG_RESET          = 8'hff;

    // Bits of the blink mask that a digit blink clear touches
    localparam logic [POS_COUNT-1:0] DIGIT_BLINK_MASK = POS_COUNT'((1 << DIGIT_COUNT) - 1);

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic [POS_W-1:0] digit;
        logic             lit;
    } result_t;

    // Common-cathode glyphs, bit 0 is segment a
    function automatic logic [SEG_W-1:0] glyph(input logic [6:0] code);
        logic [SEG_W-1:0] seg;
        unique case (code)
            7'd0:  seg = 8'h3f;
            7'd1:  seg = 8'h06;
            7'd2:  seg = 8'h5b;
            7'd3:  seg = 8'h4f;
            7'd4:  seg = 8'h66;
            7'd5:  seg = 8'h6d;
            7'd6:  seg = 8'h7d;
            7'd7:  seg = 8'h07;
            7'd8:  seg = 8'h7f;
            7'd9:  seg = 8'h6f;
            7'h41: seg = 8'h77; // A
            7'h61: seg = 8'h5f; // a
            7'h42: seg = 8'h7f; // B
            7'h62: seg = 8'h7c; // b
            7'h43: seg = 8'h39; // C
            7'h63: seg = 8'h58; // c
            7'h44: seg = 8'h3f; // D
            7'h64: seg = 8'h5e; // d
            7'h45: seg = 8'h79; // E
            7'h65: seg = 8'h7b; // e
            7'h46: seg = 8'h71; // F
            7'h47: seg = 8'h7d; // G
            7'h67: seg = 8'h6f; // g
            7'h48: seg = 8'h76; // H
            7'h68: seg = 8'h74; // h
            7'h49: seg = 8'h06; // I
            7'h4a: seg = 8'h0e; // J
            7'h4c: seg = 8'h38; // L
            7'h6e: seg = 8'h54; // n
            7'h4f: seg = 8'h3f; // O
            7'h6f: seg = 8'h5c; // o
            7'h50: seg = 8'h73; // P
            7'h71: seg = 8'h67; // q
            7'h72: seg = 8'h50; // r
            7'h53: seg = 8'h6d; // S
            7'h74: seg = 8'h78; // t
            7'h55: seg = 8'h3e; // U
            7'h79: seg = 8'h6e; // y
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

FILE: hdl/ssbd_ifs.sv
// Valid/ready channel interfaces for requests and results.
interface ssbd_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [2:0] position;
    logic [6:0] char_code;
    logic [2:0] range_end;

    modport source (output valid, mode, position, char_code, range_end, input ready);
    modport sink (input valid, mode, position, char_code, range_end, output ready);
endinterface

interface ssbd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] segments;
    logic [2:0] digit;
    logic       lit;

    modport source (output valid, segments, digit, lit, input ready);
    modport sink (input valid, segments, digit, lit, output ready);
endinterface

FILE: hdl/ssbd_out_buf.sv
// Two-entry result buffer: output register plus skid stage.
module ssbd_out_buf
    import ssbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  result_t           push_data,
    output logic              room,
    ssbd_res_if.source        res
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg, main_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop  = main_valid_reg & res.ready;
    assign room = ~skid_valid_reg;

    // Buffer next state
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end
        else if (!main_valid_reg)
        begin
            main_valid_next = push;
            main_data_next  = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    // Control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload flops
    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign res.valid    = main_valid_reg;
    assign res.segments = main_data_reg.segments;
    assign res.digit    = main_data_reg.digit;
    assign res.lit      = main_data_reg.lit;

endmodule

FILE: hdl/seven_segment_scan_blink_driver.sv
// Multiplexed eight-position seven-segment display driver with blinking.
//
// Requests arrive on cmd (valid/ready): mode 0 is a scan tick, mode 1 writes
// a decoded character into a position, mode 2 sets blink bits over a range
// of positions, mode 3 clears the digit blink bits. Only a tick gives a
// result on res (valid/ready): the segment byte, the scanned position and
// the common-line enable, blanked while the position blinks off.
// A tick's result is registered before it reaches res. Throughput: one
// request per clock while cmd.ready is high; the scan, blink and segment
// registers update as a request is taken. The result side has an output
// register and a skid stage; cmd.ready drops only while both hold results,
// so a stalled receiver blocks requests after two waiting results. Blink
// enable and period are set over the APB port (offset 0x0 and 0x4), written
// only while no request is in flight; the block does not enforce this.
// Reset clears the scan to position 0, the blink phase and the blink mask,
// sets every segment byte to 0xff, blink off and period 200 frames.
`include "seven_segment_scan_blink_driver_defines.svh"

module seven_segment_scan_blink_driver
    import ssbd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    ssbd_cmd_if.sink           cmd,
    ssbd_res_if.source         res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic                  blink_enable_reg;
    logic [PERIOD_W-1:0]   blink_period_reg;
    logic [POS_W-1:0]      scan_position_reg, scan_position_next;
    logic [PERIOD_W-1:0]   blink_phase_reg, blink_phase_next;
    logic [POS_COUNT-1:0]  blink_mask_reg, blink_mask_next;
    logic [SEG_W-1:0]      segment_store_reg [POS_COUNT];

    logic                  cmd_acc;
    logic                  tick_acc;
    logic                  room;
    logic                  cfg_wr;
    logic                  blanked;
    logic [SEG_W-1:0]      seg_sel;
    logic [PERIOD_W-1:0]   phase_inc;
    logic [POS_COUNT-1:0]  range_bits;
    result_t               result;

    assign cmd.ready = room;
    assign cmd_acc   = cmd.valid & room;
    assign tick_acc  = cmd_acc & (cmd.mode == MODE_TICK);

    // APB register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_enable_reg <= 1'b0;
            blink_period_reg <= BLINK_PERIOD_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_BLINK_ENABLE: blink_enable_reg <= pwdata[0];
                REG_BLINK_PERIOD: blink_period_reg <= pwdata[PERIOD_W-1:0];
                default:          blink_enable_reg <= blink_enable_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_BLINK_ENABLE: prdata = PDATA_W'(blink_enable_reg);
            REG_BLINK_PERIOD: prdata = PDATA_W'(blink_period_reg);
            default:          prdata = '0;
        endcase
    end

    // Current scan output
    assign blanked = blink_mask_reg[scan_position_reg] & blink_enable_reg
                     & (blink_phase_reg < (blink_period_reg >> 1));
    assign seg_sel = (scan_position_reg == COLON_POS) ?
                     {SEG_W{blink_mask_reg[COLON_POS]}} :
                     segment_store_reg[scan_position_reg];

    assign result.segments = blanked ? '0 : seg_sel;
    assign result.digit    = scan_position_reg;
    assign result.lit      = ~blanked;

    // Blink range decode
    always_comb
    begin
        for (int k = 0; k < POS_COUNT; k++)
        begin
            range_bits[k] = (POS_W'(k) >= cmd.position) && (POS_W'(k) <= cmd.range_end);
        end
    end

    assign phase_inc = blink_phase_reg + PERIOD_W'(1);

    // Scan, blink phase and blink mask update
    always_comb
    begin
        scan_position_next = scan_position_reg;
        blink_phase_next   = blink_phase_reg;
        blink_mask_next    = blink_mask_reg;
        if (cmd_acc)
        begin
            unique case (cmd.mode)
                MODE_TICK:
                begin
                    scan_position_next = scan_position_reg + POS_W'(1);
                    if (scan_position_reg == LED_POS)
                    begin
                        blink_phase_next = (phase_inc >= blink_period_reg) ? '0 : phase_inc;
                    end
                end
                MODE_SET_BLINK:   blink_mask_next = blink_mask_reg | range_bits;
                MODE_CLEAR_BLINK: blink_mask_next = blink_mask_reg & ~DIGIT_BLINK_MASK;
                default:          blink_mask_next = blink_mask_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_position_reg <= '0;
            blink_phase_reg   <= '0;
            blink_mask_reg    <= '0;
        end
        else
        begin
            scan_position_reg <= scan_position_next;
            blink_phase_reg   <= blink_phase_next;
            blink_mask_reg    <= blink_mask_next;
        end
    end

    // Segment store, one decoded glyph written per character request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < POS_COUNT; k++)
            begin
                segment_store_reg[k] <= SEG_RESET;
            end
        end
        else if (cmd_acc && (cmd.mode == MODE_WRITE_CHAR))
        begin
            segment_store_reg[cmd.position] <= glyph(cmd.char_code);
        end
    end

    ssbd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tick_acc),
        .push_data (result),
        .room      (room),
        .res       (res)
    );

    // Checks
    `SSBD_ASSERT_IMPL(a_blank_dark, clk, rst_n, res.valid && !res.lit, res.segments == '0)
    `SSBD_ASSERT_NEXT(a_scan_wrap, clk, rst_n, tick_acc && (scan_position_reg == LED_POS), scan_position_reg == '0)
    `SSBD_ASSERT_NEXT(a_scan_hold, clk, rst_n, !tick_acc, $stable(scan_position_reg))
    `SSBD_ASSERT_IMPL(a_ready_valid, clk, rst_n, !cmd.ready, res.valid)

endmodule
